### hw/rtl/cvd_pkg.sv
// Package for the count vector distance unit: widths, metric codes and constants.
// Also holds the elaboration-time builder for the log2 fraction table.
// No dependencies.
package cvd_pkg;

   localparam int COUNT_BITS_DEF    = 16;
   localparam int LOG_FRAC_BITS_DEF = 16;
   localparam int QUEUE_DEPTH_DEF   = 8;

   localparam int SUM_BITS    = 48;
   localparam int METRIC_BITS = 2;
   localparam int TAB_DEPTH   = 256;
   localparam int IDX_BITS    = 8;

   // metric register codes; the last two codes both select the penalty metric
   localparam logic [METRIC_BITS-1:0] METRIC_SQ_EUCLID = 2'd0;
   localparam logic [METRIC_BITS-1:0] METRIC_LOG_L1    = 2'd1;
   localparam logic [METRIC_BITS-1:0] METRIC_LOG_PEN   = 2'd2;
   localparam logic [METRIC_BITS-1:0] METRIC_LOG_PEN_B = 2'd3;
   localparam logic [METRIC_BITS-1:0] METRIC_RESET     = METRIC_LOG_L1;

   localparam int LN2_Q16      = 45426;
   localparam int LN2_ROUND    = 32768;
   localparam int LN2_SHIFT    = 16;
   localparam int PENALTY_INT  = 3;
   localparam int TAB_RAW_BITS = 24;

   localparam logic [SUM_BITS-1:0] SUM_MAX = {SUM_BITS{1'b1}};

   // log2(1 + idx/256) in Q0.24, bit by bit through repeated squaring
   function automatic logic [31:0] log2_frac24(input int unsigned idx);
      logic [63:0] y;
      logic [63:0] r;
      y = 64'(TAB_DEPTH + idx) << 22;
      r = 64'd0;
      for (int n = 0; n < 28; n++) begin
         y = (y * y) >> 30;
         r = r << 1;
         if (y >= (64'd1 << 31)) begin
            r = r | 64'd1;
            y = y >> 1;
         end
      end
      return 32'((r + 64'd8) >> 4);
   endfunction

   // table entry rounded half up to frac_bits fraction bits
   function automatic logic [31:0] frac_entry(input int unsigned idx,
                                              input int unsigned frac_bits);
      logic [31:0] t;
      int unsigned drop;
      t    = log2_frac24(idx);
      drop = TAB_RAW_BITS - frac_bits;
      if (drop > 0) begin
         t = (t + (32'd1 << (drop - 1))) >> drop;
      end
      return t;
   endfunction

endpackage

### hw/rtl/cvd_req_if.sv
// Request channel of the count vector distance unit: one element pair per word.
// Depends on cvd_pkg for the default count width.
interface cvd_req_if #(
   parameter int COUNT_BITS = cvd_pkg::COUNT_BITS_DEF
) ();
   logic                  valid;
   logic                  ready;
   logic [COUNT_BITS-1:0] count_a;
   logic [COUNT_BITS-1:0] count_b;
   logic                  last_element;

   modport source (output valid, count_a, count_b, last_element, input ready);
   modport sink   (input valid, count_a, count_b, last_element, output ready);
endinterface

### hw/rtl/cvd_rsp_if.sv
// Response channel of the count vector distance unit: one distance per word.
// Depends on cvd_pkg for the sum width.
interface cvd_rsp_if ();
   logic                          valid;
   logic                          ready;
   logic [cvd_pkg::SUM_BITS-1:0] distance;

   modport source (output valid, distance, input ready);
   modport sink   (input valid, distance, output ready);
endinterface

### hw/rtl/cvd_front.sv
// Front end: accepts element pairs and computes each element's distance term
// in a three-stage pipeline (log lookup, ln2 scaling / square, term select).
// Depends on cvd_pkg.
module cvd_front #(
   parameter int COUNT_BITS    = cvd_pkg::COUNT_BITS_DEF,
   parameter int LOG_FRAC_BITS = cvd_pkg::LOG_FRAC_BITS_DEF,
   parameter int QUEUE_DEPTH   = cvd_pkg::QUEUE_DEPTH_DEF,
   parameter int TERM_BITS     = 2 * cvd_pkg::COUNT_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [cvd_pkg::METRIC_BITS-1:0]     metric,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  logic [COUNT_BITS-1:0]               count_a,
   input  logic [COUNT_BITS-1:0]               count_b,
   input  logic                                last_element,
   input  logic [$clog2(QUEUE_DEPTH+1)-1:0]    q_count,
   output logic                                push_valid,
   output logic [TERM_BITS-1:0]                push_term,
   output logic                                push_last
);
   import cvd_pkg::*;

   localparam int KW  = $clog2(COUNT_BITS + 1);
   localparam int L2W = KW + LOG_FRAC_BITS;
   localparam int PW  = L2W + LN2_SHIFT;
   localparam int CW  = $clog2(QUEUE_DEPTH + 1);

   // log2 fraction table, built at elaboration
   logic [LOG_FRAC_BITS-1:0] frac_tab [TAB_DEPTH];
   for (genvar g = 0; g < TAB_DEPTH; g++) begin : g_tab
      localparam logic [31:0] ENTRY = frac_entry(g, LOG_FRAC_BITS);
      assign frac_tab[g] = ENTRY[LOG_FRAC_BITS-1:0];
   end

   // position of the leading one
   function automatic logic [KW-1:0] lead_pos(input logic [COUNT_BITS:0] v);
      logic [KW-1:0] k;
      k = '0;
      for (int b = 0; b <= COUNT_BITS; b++) begin
         if (v[b]) begin
            k = KW'(b);
         end
      end
      return k;
   endfunction

   // stage registers
   logic                     s1_valid_ff, s1_valid_in;
   logic [L2W-1:0]           s1_l2a_ff, s1_l2a_in;
   logic [L2W-1:0]           s1_l2b_ff, s1_l2b_in;
   logic [COUNT_BITS-1:0]    s1_diff_ff, s1_diff_in;
   logic                     s1_log_ff, s1_log_in;
   logic                     s1_pen_ff, s1_pen_in;
   logic                     s1_last_ff, s1_last_in;

   logic                     s2_valid_ff;
   logic [L2W-1:0]           s2_lna_ff, s2_lna_in;
   logic [L2W-1:0]           s2_lnb_ff, s2_lnb_in;
   logic [2*COUNT_BITS-1:0]  s2_sq_ff, s2_sq_in;
   logic                     s2_log_ff;
   logic                     s2_pen_ff;
   logic                     s2_last_ff;

   logic                     s3_valid_ff;
   logic [TERM_BITS-1:0]     s3_term_ff, s3_term_in;
   logic                     s3_last_ff;

   logic [COUNT_BITS:0]      va, vb, vna, vnb;
   logic [KW-1:0]            ka, kb;
   logic [IDX_BITS-1:0]      idxa, idxb;
   logic [PW-1:0]            prod_a, prod_b;
   logic [L2W-1:0]           ln_diff;
   logic [TERM_BITS-1:0]     pen_add;
   logic [CW:0]              occupancy;

   // hold back input when the queue could not absorb everything in flight
   assign occupancy = (CW+1)'(q_count) + (CW+1)'(s1_valid_ff) + (CW+1)'(s2_valid_ff)
                      + (CW+1)'(s3_valid_ff);
   assign in_ready  = occupancy < (CW+1)'(QUEUE_DEPTH);

   // stage 1: log2 by leading one and fraction table, plain difference
   always_comb begin
      va   = {1'b0, count_a} + (COUNT_BITS+1)'(1);
      vb   = {1'b0, count_b} + (COUNT_BITS+1)'(1);
      ka   = lead_pos(va);
      kb   = lead_pos(vb);
      vna  = va << (KW'(COUNT_BITS) - ka);
      vnb  = vb << (KW'(COUNT_BITS) - kb);
      idxa = vna[COUNT_BITS-1 -: IDX_BITS];
      idxb = vnb[COUNT_BITS-1 -: IDX_BITS];
      s1_valid_in = in_valid && in_ready;
      s1_l2a_in   = {ka, frac_tab[idxa]};
      s1_l2b_in   = {kb, frac_tab[idxb]};
      s1_diff_in  = (count_a >= count_b) ? count_a - count_b : count_b - count_a;
      s1_log_in   = metric != METRIC_SQ_EUCLID;
      s1_pen_in   = (metric inside {METRIC_LOG_PEN, METRIC_LOG_PEN_B})
                    && ((count_a == '0) != (count_b == '0));
      s1_last_in  = last_element;
   end

   // stage 2: scale by ln2 with rounding, square the difference
   always_comb begin
      prod_a    = PW'(s1_l2a_ff) * PW'(LN2_Q16) + PW'(LN2_ROUND);
      prod_b    = PW'(s1_l2b_ff) * PW'(LN2_Q16) + PW'(LN2_ROUND);
      s2_lna_in = prod_a[PW-1:LN2_SHIFT];
      s2_lnb_in = prod_b[PW-1:LN2_SHIFT];
      s2_sq_in  = (2*COUNT_BITS)'(s1_diff_ff) * (2*COUNT_BITS)'(s1_diff_ff);
   end

   // stage 3: pick the term for the metric
   always_comb begin
      ln_diff    = (s2_lna_ff >= s2_lnb_ff) ? s2_lna_ff - s2_lnb_ff : s2_lnb_ff - s2_lna_ff;
      pen_add    = s2_pen_ff ? (TERM_BITS'(PENALTY_INT) << LOG_FRAC_BITS) : '0;
      s3_term_in = s2_log_ff ? TERM_BITS'(ln_diff) + pen_add : TERM_BITS'(s2_sq_ff);
   end

   // advance the pipeline every cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
      s1_l2a_ff  <= s1_l2a_in;
      s1_l2b_ff  <= s1_l2b_in;
      s1_diff_ff <= s1_diff_in;
      s1_log_ff  <= s1_log_in;
      s1_pen_ff  <= s1_pen_in;
      s1_last_ff <= s1_last_in;
      s2_lna_ff  <= s2_lna_in;
      s2_lnb_ff  <= s2_lnb_in;
      s2_sq_ff   <= s2_sq_in;
      s2_log_ff  <= s1_log_ff;
      s2_pen_ff  <= s1_pen_ff;
      s2_last_ff <= s1_last_ff;
      s3_term_ff <= s3_term_in;
      s3_last_ff <= s2_last_ff;
   end

   assign push_valid = s3_valid_ff;
   assign push_term  = s3_term_ff;
   assign push_last  = s3_last_ff;

endmodule

### hw/rtl/cvd_queue.sv
// Small queue that parts the term pipeline from the accumulator.
// Depends on cvd_pkg only for the default width and depth.
module cvd_queue #(
   parameter int WIDTH = 2 * cvd_pkg::COUNT_BITS_DEF + 1,
   parameter int DEPTH = cvd_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  logic [WIDTH-1:0]               push_data,
   input  logic                           pop,
   output logic                           pop_valid,
   output logic [WIDTH-1:0]               pop_data,
   output logic [$clog2(DEPTH+1)-1:0]     count
);
   import cvd_pkg::*;

   localparam int PTW = $clog2(DEPTH);
   localparam int CW  = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [PTW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   // advance pointers with explicit wrap
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_valid = count_ff != '0;
   assign pop_data  = mem[rd_ptr_ff];
   assign count     = count_ff;

endmodule

### hw/rtl/cvd_accum.sv
// Back end: adds queued terms into the saturating running sum and emits the
// distance on the last element through an output register. Depends on cvd_pkg.
module cvd_accum #(
   parameter int TERM_BITS = 2 * cvd_pkg::COUNT_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_valid,
   input  logic [TERM_BITS-1:0]          q_term,
   input  logic                          q_last,
   output logic                          q_pop,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [cvd_pkg::SUM_BITS-1:0]  distance
);
   import cvd_pkg::*;

   localparam int AW = ((SUM_BITS > TERM_BITS) ? SUM_BITS : TERM_BITS) + 1;

   logic [SUM_BITS-1:0] sum_ff, sum_in;
   logic [SUM_BITS-1:0] dist_ff, dist_in;
   logic                valid_ff, valid_in;
   logic [AW-1:0]       total;
   logic [SUM_BITS-1:0] sat_sum;

   // pop unless the term is a last one and a finished distance is still waiting
   assign q_pop = q_valid && (!q_last || !valid_ff || out_ready);

   // saturating add
   always_comb begin
      total   = AW'(sum_ff) + AW'(q_term);
      sat_sum = (total > AW'(SUM_MAX)) ? SUM_MAX : total[SUM_BITS-1:0];
   end

   always_comb begin
      sum_in   = sum_ff;
      dist_in  = dist_ff;
      valid_in = valid_ff && !out_ready;
      if (q_pop) begin
         if (q_last) begin
            dist_in  = sat_sum;
            valid_in = 1'b1;
            sum_in   = '0;
         end else begin
            sum_in = sat_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         sum_ff   <= sum_in;
         valid_ff <= valid_in;
      end
      dist_ff <= dist_in;
   end

   assign out_valid = valid_ff;
   assign distance  = dist_ff;

endmodule

### hw/rtl/count_vector_distance_unit.sv
// Count vector distance unit: streaming squared-Euclidean, log-L1 or penalised log-L1 distance.
// Path: the last element's term passes term stages 1 to 3 and the queue; the distance is held in the output register.
// Throughput: one element per cycle while req_ch.ready is high; the queue absorbs QUEUE_DEPTH - 3 words of
// response stall before req_ch.ready drops (three term pipeline stages in flight).
// Reset: synchronous; metric returns to log L1, the running sum clears, queue empties.
module count_vector_distance_unit #(
   parameter int COUNT_BITS    = cvd_pkg::COUNT_BITS_DEF,
   parameter int LOG_FRAC_BITS = cvd_pkg::LOG_FRAC_BITS_DEF,
   parameter int QUEUE_DEPTH   = cvd_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   cvd_req_if.sink                          req_ch,
   cvd_rsp_if.source                        rsp_ch,
   input  logic                             csr_we,
   input  logic [cvd_pkg::METRIC_BITS-1:0]  csr_wdata
);
   import cvd_pkg::*;

   localparam int KW        = $clog2(COUNT_BITS + 1);
   localparam int L2W       = KW + LOG_FRAC_BITS;
   localparam int TERM_BITS = (2 * COUNT_BITS > L2W + 1) ? 2 * COUNT_BITS : L2W + 1;
   localparam int CW        = $clog2(QUEUE_DEPTH + 1);

   logic [METRIC_BITS-1:0] metric_ff;
   logic                   push_valid;
   logic [TERM_BITS-1:0]   push_term;
   logic                   push_last;
   logic                   q_pop;
   logic                   q_valid;
   logic [TERM_BITS:0]     q_data;
   logic [CW-1:0]          q_count;

   // metric register
   always_ff @(posedge clock) begin
      if (reset) begin
         metric_ff <= METRIC_RESET;
      end else if (csr_we) begin
         metric_ff <= csr_wdata;
      end
   end

   cvd_front #(
      .COUNT_BITS    (COUNT_BITS),
      .LOG_FRAC_BITS (LOG_FRAC_BITS),
      .QUEUE_DEPTH   (QUEUE_DEPTH),
      .TERM_BITS     (TERM_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .metric       (metric_ff),
      .in_valid     (req_ch.valid),
      .in_ready     (req_ch.ready),
      .count_a      (req_ch.count_a),
      .count_b      (req_ch.count_b),
      .last_element (req_ch.last_element),
      .q_count      (q_count),
      .push_valid   (push_valid),
      .push_term    (push_term),
      .push_last    (push_last)
   );

   cvd_queue #(
      .WIDTH (TERM_BITS + 1),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_data ({push_last, push_term}),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_data  (q_data),
      .count     (q_count)
   );

   cvd_accum #(
      .TERM_BITS (TERM_BITS)
   ) u_accum (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_term    (q_data[TERM_BITS-1:0]),
      .q_last    (q_data[TERM_BITS]),
      .q_pop     (q_pop),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .distance  (rsp_ch.distance)
   );

endmodule
